// File: hdl/yuvargb_pkg.sv
// shared types and fixed-point constants for the yuv 4:2:0 pair to argb converter
package yuvargb_pkg;

    // input word: one pixel pair with its shared chroma
    typedef struct packed {
        logic [7:0] luma_left;
        logic [7:0] luma_right;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       right_present;
    } t_pix_in;

    // result word: one argb pixel
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_pair;
    } t_pix_out;

    localparam int OFF_W  = 10;
    localparam int PROD_W = 27;
    localparam int LANE_W = 28;

    // chroma offsets plus the two luma samples that go with them
    typedef struct packed {
        logic [7:0]              luma_left;
        logic [7:0]              luma_right;
        logic signed [OFF_W-1:0] off_r;
        logic signed [OFF_W-1:0] off_g;
        logic signed [OFF_W-1:0] off_b;
    } t_chroma;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam logic signed [17:0] K_R_V = 18'sd89858;
    localparam logic signed [17:0] K_G_V = -18'sd45773;
    localparam logic signed [17:0] K_G_U = -18'sd22014;
    localparam logic signed [17:0] K_B_U = 18'sd113618;
    localparam logic signed [17:0] K_Y   = 18'sd76283;
    localparam int                 ROUND_HALF = 32768;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;
    localparam int                 LUMA_BLACK = 16;

endpackage

// File: hdl/yuvargb_chroma.sv
// chroma offset pipeline: four constant multiplies, then round and shift
module yuvargb_chroma (
    input  logic                  i_clk,
    input  yuvargb_pkg::t_pix_in  i_pix,
    output yuvargb_pkg::t_chroma  o_chroma
);

    localparam int PW = yuvargb_pkg::PROD_W;
    localparam int OW = yuvargb_pkg::OFF_W;

    logic signed [7:0]    w_u;
    logic signed [7:0]    w_v;
    logic signed [PW-1:0] r_p_rv;
    logic signed [PW-1:0] r_p_gv;
    logic signed [PW-1:0] r_p_gu;
    logic signed [PW-1:0] r_p_bu;
    logic [7:0]           r_luma_l;
    logic [7:0]           r_luma_r;
    logic signed [PW-1:0] w_s_r;
    logic signed [PW-1:0] w_s_g;
    logic signed [PW-1:0] w_s_b;
    yuvargb_pkg::t_chroma r_out;

    // sample minus 128 is the sample with its top bit flipped, read as signed
    assign w_u = {~i_pix.chroma_u[7], i_pix.chroma_u[6:0]};
    assign w_v = {~i_pix.chroma_v[7], i_pix.chroma_v[6:0]};

    always_ff @(posedge i_clk) begin
        r_p_rv   <= PW'(w_v) * PW'(yuvargb_pkg::K_R_V);
        r_p_gv   <= PW'(w_v) * PW'(yuvargb_pkg::K_G_V);
        r_p_gu   <= PW'(w_u) * PW'(yuvargb_pkg::K_G_U);
        r_p_bu   <= PW'(w_u) * PW'(yuvargb_pkg::K_B_U);
        r_luma_l <= i_pix.luma_left;
        r_luma_r <= i_pix.luma_right;
    end

    assign w_s_r = r_p_rv + PW'(yuvargb_pkg::ROUND_HALF);
    assign w_s_g = r_p_gv + r_p_gu + PW'(yuvargb_pkg::ROUND_HALF);
    assign w_s_b = r_p_bu + PW'(yuvargb_pkg::ROUND_HALF);

    // floor shift by 16: the offsets fit easily in the kept bits
    always_ff @(posedge i_clk) begin
        r_out.luma_left  <= r_luma_l;
        r_out.luma_right <= r_luma_r;
        r_out.off_r      <= w_s_r[16+OW-1:16];
        r_out.off_g      <= w_s_g[16+OW-1:16];
        r_out.off_b      <= w_s_b[16+OW-1:16];
    end

    assign o_chroma = r_out;

endmodule

// File: hdl/yuvargb_lane.sv
// one pixel lane: luma plus offsets, scale by the luma gain, round and clamp
module yuvargb_lane (
    input  logic                                i_clk,
    input  logic [7:0]                          i_luma,
    input  logic signed [yuvargb_pkg::OFF_W-1:0] i_off_r,
    input  logic signed [yuvargb_pkg::OFF_W-1:0] i_off_g,
    input  logic signed [yuvargb_pkg::OFF_W-1:0] i_off_b,
    output yuvargb_pkg::t_rgb                   o_rgb
);

    localparam int LW = yuvargb_pkg::LANE_W;
    localparam int TW = 11;

    logic signed [TW-1:0] w_y;
    logic signed [TW-1:0] w_t_r;
    logic signed [TW-1:0] w_t_g;
    logic signed [TW-1:0] w_t_b;
    logic signed [LW-1:0] r_p_r;
    logic signed [LW-1:0] r_p_g;
    logic signed [LW-1:0] r_p_b;
    yuvargb_pkg::t_rgb    r_rgb;

    function automatic logic [7:0] clamp8(input logic signed [LW-1:0] p);
        logic signed [LW-1:0] s;
        logic signed [LW-17:0] j;
        s = p + LW'(yuvargb_pkg::ROUND_HALF);
        j = s[LW-1:16];
        if (j < 0) begin
            clamp8 = 8'd0;
        end else if (j > (LW-16)'(255)) begin
            clamp8 = 8'd255;
        end else begin
            clamp8 = j[7:0];
        end
    endfunction

    assign w_y   = $signed({3'b000, i_luma}) - TW'(yuvargb_pkg::LUMA_BLACK);
    assign w_t_r = w_y + TW'(i_off_r);
    assign w_t_g = w_y + TW'(i_off_g);
    assign w_t_b = w_y + TW'(i_off_b);

    always_ff @(posedge i_clk) begin
        r_p_r <= LW'(w_t_r) * LW'(yuvargb_pkg::K_Y);
        r_p_g <= LW'(w_t_g) * LW'(yuvargb_pkg::K_Y);
        r_p_b <= LW'(w_t_b) * LW'(yuvargb_pkg::K_Y);
    end

    always_ff @(posedge i_clk) begin
        r_rgb.red   <= clamp8(r_p_r);
        r_rgb.green <= clamp8(r_p_g);
        r_rgb.blue  <= clamp8(r_p_b);
    end

    assign o_rgb = r_rgb;

endmodule

// File: hdl/yuv420_pair_to_argb.sv
// top level: chroma pipeline, left and right pixel lanes, output merge
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+-------------------------------
//   pair in  | start, busy, i_pix         | taken when start & !busy
//   pixel out| o_valid, o_pix             | o_valid per word, no stall
//
// a pair passes 2 chroma stages, 2 lane stages and the output register. a new
// pair or lone pixel can be taken while earlier ones are still in the pipe. a
// full pair needs the single output port twice, so busy is high for one cycle
// after a full pair is taken. synchronous reset clears the valid pipe, the
// pending right pixel and busy.
module yuv420_pair_to_argb (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  yuvargb_pkg::t_pix_in  i_pix,
    output logic                  o_valid,
    output yuvargb_pkg::t_pix_out o_pix
);

    localparam int DEPTH = 4;

    logic                  w_accept;
    logic                  r_busy;
    logic [DEPTH-1:0]      r_vld;
    logic [DEPTH-1:0]      r_two;
    yuvargb_pkg::t_chroma  w_chroma;
    yuvargb_pkg::t_rgb     w_left;
    yuvargb_pkg::t_rgb     w_right;
    yuvargb_pkg::t_rgb     r_hold;
    logic                  r_hold_v;
    logic                  n_hold_v;
    logic                  r_out_v;
    logic                  n_out_v;
    yuvargb_pkg::t_pix_out r_out;
    yuvargb_pkg::t_pix_out n_out;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    yuvargb_chroma u_chroma (
        .i_clk    (i_clk),
        .i_pix    (i_pix),
        .o_chroma (w_chroma)
    );

    yuvargb_lane u_lane_left (
        .i_clk   (i_clk),
        .i_luma  (w_chroma.luma_left),
        .i_off_r (w_chroma.off_r),
        .i_off_g (w_chroma.off_g),
        .i_off_b (w_chroma.off_b),
        .o_rgb   (w_left)
    );

    yuvargb_lane u_lane_right (
        .i_clk   (i_clk),
        .i_luma  (w_chroma.luma_right),
        .i_off_r (w_chroma.off_r),
        .i_off_g (w_chroma.off_g),
        .i_off_b (w_chroma.off_b),
        .o_rgb   (w_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_busy <= w_accept && i_pix.right_present;
            r_vld  <= {r_vld[DEPTH-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_two <= {r_two[DEPTH-2:0], i_pix.right_present};
    end

    // merge: left pixel goes out at once, right one waits in r_hold and follows in the next cycle
    always_comb begin
        n_hold_v            = 1'b0;
        n_out_v             = 1'b0;
        n_out.alpha         = yuvargb_pkg::ALPHA_OPAQUE;
        n_out.red           = r_hold.red;
        n_out.green         = r_hold.green;
        n_out.blue          = r_hold.blue;
        n_out.last_of_pair  = 1'b1;
        if (r_vld[DEPTH-1]) begin
            n_out_v            = 1'b1;
            n_out.red          = w_left.red;
            n_out.green        = w_left.green;
            n_out.blue         = w_left.blue;
            n_out.last_of_pair = !r_two[DEPTH-1];
            n_hold_v           = r_two[DEPTH-1];
        end else if (r_hold_v) begin
            n_out_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_vld[DEPTH-1]) begin
            r_hold <= w_right;
        end
    end

    assign o_valid = r_out_v;
    assign o_pix   = r_out;

endmodule
